// ===== design/fte_pkg.sv =====
package fte_pkg;

    localparam int DateW  = 16;
    localparam int TimeW  = 16;
    localparam int EpochW = 32;
    localparam int DaysW  = 16;
    localparam int DaySecW = 33;
    localparam int TodSecW = 17;

    localparam logic [16:0] SecsPerDay   = 17'd86400;
    localparam logic [11:0] SecsPerHour  = 12'd3600;
    localparam logic [5:0]  SecsPerMin   = 6'd60;
    // Days from 1970-01-01 to 1980-01-01.
    localparam logic [15:0] DaysTo1980   = 16'd3652;
    // Year offset of 2100, the only non-leap year divisible by 4 in range.
    localparam logic [6:0]  Year2100Off  = 7'd120;
    localparam logic [3:0]  MonthFeb     = 4'd2;
    localparam logic [3:0]  MonthDec     = 4'd12;
    localparam logic [4:0]  MaxHour      = 5'd23;
    localparam logic [5:0]  MaxMinute    = 6'd59;
    localparam logic [4:0]  MaxTwoSec    = 5'd29;

    typedef struct packed {
        logic             ok;
        logic [DaysW-1:0] days;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
    } fte_dec_t;

    typedef struct packed {
        logic               ok;
        logic [DaySecW-1:0] day_secs;
        logic [TodSecW-1:0] tod_secs;
    } fte_scl_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] l;
        case (month)
            4'd2:                   l = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
            default:                l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

// ===== design/fte_decode.sv =====
module fte_decode (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [fte_pkg::DateW-1:0] packed_date,
    input  logic [fte_pkg::TimeW-1:0] packed_time,
    output logic                     out_valid,
    output fte_pkg::fte_dec_t        out_data
);
    import fte_pkg::*;

    logic       valid_reg, valid_next;
    fte_dec_t   data_reg, data_next;

    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] yoff;
    logic [4:0] two_sec;
    logic [5:0] minute;
    logic [4:0] hour;
    logic       leap;
    logic       past_2100;
    logic [15:0] year_days;

    always_comb begin
        day     = packed_date[4:0];
        month   = packed_date[8:5];
        yoff    = packed_date[15:9];
        two_sec = packed_time[4:0];
        minute  = packed_time[10:5];
        hour    = packed_time[15:11];

        leap      = (yoff[1:0] == 2'b00) && (yoff != Year2100Off);
        past_2100 = yoff > Year2100Off;
        // 365 per year plus leap days in the years before this one.
        year_days = DaysTo1980 + 16'(yoff) * 16'd365 + 16'((8'(yoff) + 8'd3) >> 2)
                    - 16'(past_2100);

        data_next.ok = (month != 4'd0) && (month <= MonthDec) && (day != 5'd0) &&
                       (hour <= MaxHour) && (minute <= MaxMinute) &&
                       (two_sec <= MaxTwoSec) && (day <= month_len(month, leap));
        data_next.days = year_days + 16'(days_before_month(month))
                         + 16'(leap && (month > MonthFeb)) + 16'(day) - 16'd1;
        data_next.hour   = hour;
        data_next.minute = minute;
        data_next.second = {two_sec, 1'b0};
        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/fte_scale.sv =====
module fte_scale (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  fte_pkg::fte_dec_t in_data,
    output logic              out_valid,
    output fte_pkg::fte_scl_t out_data
);
    import fte_pkg::*;

    logic     valid_reg, valid_next;
    fte_scl_t data_reg, data_next;

    always_comb begin
        data_next.ok       = in_data.ok;
        data_next.day_secs = DaySecW'(in_data.days) * DaySecW'(SecsPerDay);
        data_next.tod_secs = TodSecW'(in_data.hour) * TodSecW'(SecsPerHour)
                             + TodSecW'(in_data.minute) * TodSecW'(SecsPerMin)
                             + TodSecW'(in_data.second);
        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/fte_sum.sv =====
module fte_sum (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  fte_pkg::fte_scl_t         in_data,
    output logic                      out_valid,
    output logic [fte_pkg::EpochW-1:0] out_secs
);
    import fte_pkg::*;

    logic              valid_reg, valid_next;
    logic [EpochW-1:0] secs_reg, secs_next;
    logic [DaySecW-1:0] total;

    always_comb begin
        total = in_data.day_secs + DaySecW'(in_data.tod_secs);
        if (!in_data.ok) begin
            secs_next = '0;
        end else if (total[DaySecW-1]) begin
            secs_next = '1;
        end else begin
            secs_next = total[EpochW-1:0];
        end
        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (en) begin
            secs_reg <= secs_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_secs  = secs_reg;

endmodule

// ===== design/fat_timestamp_to_epoch_core.sv =====
// Converts a packed FAT date and time into seconds since 1970-01-01 00:00:00.
// One transfer is taken every clock cycle unless a finished result waits on
// m_tready. The pipeline has three register stages: field decode, validity
// check and day count; the constant multiplies to seconds; the final add with
// saturation, which is also the output register. All stages hold together
// while a result waits on m_tready, so s_tready is high whenever the output
// register is empty or being drained. An invalid month, day, hour, minute or
// second gives 0; a count beyond 32 bits (early February 2106 on) gives
// all ones. There is no configuration and no state beyond the pipeline.
module fat_timestamp_to_epoch_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] packed_date, [31:16] packed_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] epoch_seconds
);
    import fte_pkg::*;

    logic     advance;
    logic     dec_valid;
    fte_dec_t dec_data;
    logic     scl_valid;
    fte_scl_t scl_data;

    // Advance the whole pipeline unless a finished result is held back.
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    fte_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .in_valid    (s_tvalid),
        .packed_date (s_tdata[DateW-1:0]),
        .packed_time (s_tdata[DateW+TimeW-1:DateW]),
        .out_valid   (dec_valid),
        .out_data    (dec_data)
    );

    fte_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (dec_valid),
        .in_data   (dec_data),
        .out_valid (scl_valid),
        .out_data  (scl_data)
    );

    // Final stage drives the master side directly.
    fte_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (scl_valid),
        .in_data   (scl_data),
        .out_valid (m_tvalid),
        .out_secs  (m_tdata)
    );

endmodule

// ===== design/fte_checker.sv =====
module fte_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("transfer lost in pipeline");

    a_bad_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready && s_tdata[8:5] == 4'd0)
        ##1 m_tready ##1 m_tready |=> m_tdata == 32'd0)
        else $error("month zero not mapped to zero");

endmodule

bind fat_timestamp_to_epoch_core fte_checker u_fte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/fte_epoch_checker.sv =====
`timescale 1ns / 1ps

module fte_epoch_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] packed_date, [31:16] packed_time
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] epoch_seconds
    output int          fail_count,
    output int          pending,
    output int          checked_count,
    output int          invalid_count,
    output int          saturated_count
);

    localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned CumDays [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int unsigned YearBase  = 1980;
    localparam int unsigned EpochYear = 1970;

    logic [fte_pkg::EpochW-1:0] expected_epochs [$];
    logic [fte_pkg::EpochW-1:0] want;

    // Gregorian leap years in 1..n.
    function automatic int unsigned leaps_upto(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic logic [fte_pkg::EpochW-1:0] fat_to_epoch_seconds(
        input logic [fte_pkg::DateW-1:0] date,
        input logic [fte_pkg::TimeW-1:0] tod
    );
        logic [4:0]        day;
        logic [3:0]        month;
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        int unsigned       year;
        bit                leap;
        int unsigned       mlen;
        int unsigned       days;
        longint unsigned   secs;
        day    = date[4:0];
        month  = date[8:5];
        year   = int'(date[15:9]) + YearBase;
        second = {tod[4:0], 1'b0};
        minute = tod[10:5];
        hour   = tod[15:11];
        leap   = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        if (month < 1 || month > 12 || day < 1 || hour > 23 || minute > 59 || second > 59)
            return '0;
        mlen = MonthDays[month - 1] + ((month == 2 && leap) ? 1 : 0);
        if (day > mlen)
            return '0;
        days = 365 * (year - EpochYear) + leaps_upto(year - 1) - leaps_upto(EpochYear - 1)
             + CumDays[month - 1] + ((month > 2 && leap) ? 1 : 0) + (day - 1);
        secs = 64'(days) * 64'd86400 + 64'(hour) * 64'd3600 + 64'(minute) * 64'd60
             + 64'(second);
        return (secs > 64'hFFFF_FFFF) ? '1 : secs[31:0];
    endfunction

    assign pending = expected_epochs.size();

    initial begin
        fail_count      = 0;
        checked_count   = 0;
        invalid_count   = 0;
        saturated_count = 0;
    end

    // Retire the output side first so a stray result is never matched
    // against an input taken on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_epochs.size() == 0) begin
                    if (fail_count < 10)
                        $display("mismatch: unexpected result %08h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_epochs.pop_front();
                    checked_count++;
                    if (want == '0)
                        invalid_count++;
                    if (want == '1)
                        saturated_count++;
                    if (m_tdata !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: epoch_seconds expected %08h actual %08h",
                                     want, m_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_epochs.push_back(fat_to_epoch_seconds(s_tdata[15:0], s_tdata[31:16]));
        end
    end

endmodule

// ===== dv/tb_fat_timestamp_to_epoch_core.sv =====
`timescale 1ns / 1ps

module tb_fat_timestamp_to_epoch_core;

    localparam int CycleLimit   = 400000;
    localparam int PhaseItems   = 250;
    localparam int DrainCycles  = 12;

    // Idle and stall percentages per phase: free run, sender gaps,
    // receiver back-pressure, then both at once.
    localparam int SendIdle [4] = '{0, 71, 0, 35};
    localparam int RecvStall [4] = '{0, 0, 71, 35};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] packed_date, [31:16] packed_time
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] epoch_seconds

    int fail_count;
    int pending;
    int checked_count;
    int invalid_count;
    int saturated_count;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    always #1 aclk = ~aclk;

    fat_timestamp_to_epoch_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    fte_epoch_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .invalid_count  (invalid_count),
        .saturated_count(saturated_count)
    );

    // Drop m_tready at random according to the current phase.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the stream hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] pack_date(input int y_off, input int month, input int day);
        return {7'(y_off), 4'(month), 5'(day)};
    endfunction

    function automatic logic [15:0] pack_time(input int hour, input int minute, input int twosec);
        return {5'(hour), 6'(minute), 5'(twosec)};
    endfunction

    // Hold the word on the slave side until the transfer completes,
    // inserting idle cycles first as the phase asks.
    task automatic push_transfer(input logic [15:0] date, input logic [15:0] tod);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tod, date};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly well-formed timestamps with random content; the rest raw noise
    // or a single field pushed out of range.
    task automatic push_random;
        logic [15:0] date;
        logic [15:0] tod;
        int          pick;
        pick = $urandom_range(99);
        date = pack_date($urandom_range(127), $urandom_range(1, 12), $urandom_range(1, 31));
        tod  = pack_time($urandom_range(23), $urandom_range(59), $urandom_range(29));
        if (pick < 15) begin
            date = 16'($urandom);
            tod  = 16'($urandom);
        end else if (pick < 25) begin
            case ($urandom_range(4))
                0: date[8:5]   = 4'($urandom_range(1) ? $urandom_range(13, 15) : 0);
                1: date[4:0]   = '0;
                2: tod[15:11]  = 5'($urandom_range(24, 31));
                3: tod[10:5]   = 6'($urandom_range(60, 63));
                default: tod[4:0] = 5'($urandom_range(30, 31));
            endcase
        end
        push_transfer(date, tod);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, calendar edges and saturation.
        push_transfer(16'h0000, 16'h0000);
        push_transfer(16'hFFFF, 16'hFFFF);
        push_transfer(pack_date(0, 1, 1), pack_time(0, 0, 0));        // first instant of 1980
        push_transfer(pack_date(0, 1, 1), 16'hFFFF);
        push_transfer(pack_date(20, 2, 29), pack_time(12, 30, 15));   // leap day, 2000
        push_transfer(pack_date(20, 3, 1), pack_time(0, 0, 0));
        push_transfer(pack_date(1, 2, 29), pack_time(0, 0, 0));       // no leap day in 1981
        push_transfer(pack_date(120, 2, 29), pack_time(0, 0, 0));     // 2100 is not leap
        push_transfer(pack_date(120, 2, 28), pack_time(23, 59, 29));
        push_transfer(pack_date(120, 3, 1), pack_time(0, 0, 0));
        push_transfer(pack_date(5, 0, 10), pack_time(1, 1, 1));       // month zero
        push_transfer(pack_date(5, 13, 10), pack_time(1, 1, 1));
        push_transfer(pack_date(5, 15, 10), pack_time(1, 1, 1));
        push_transfer(pack_date(5, 6, 0), pack_time(1, 1, 1));        // day zero
        push_transfer(pack_date(5, 4, 31), pack_time(1, 1, 1));       // April has 30
        push_transfer(pack_date(5, 12, 31), pack_time(23, 59, 29));
        push_transfer(pack_date(5, 7, 4), pack_time(24, 0, 0));       // hour out of range
        push_transfer(pack_date(5, 7, 4), pack_time(10, 60, 0));      // minute out of range
        push_transfer(pack_date(5, 7, 4), pack_time(10, 10, 30));     // seconds out of range
        push_transfer(pack_date(126, 2, 7), pack_time(6, 28, 7));     // one below the top
        push_transfer(pack_date(126, 2, 7), pack_time(6, 28, 8));     // just past 32 bits
        push_transfer(pack_date(127, 12, 31), pack_time(23, 59, 29)); // last representable
        push_transfer(pack_date(126, 1, 1), pack_time(0, 0, 0));

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = SendIdle[phase];
            stall_pct <= RecvStall[phase];
            repeat (PhaseItems) push_random();
        end
        s_tvalid <= 1'b0;

        // Let the checker record the last transfer before polling its queue.
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("checked %0d conversions over four handshake phases", checked_count);
        $display("%0d gave zero (invalid), %0d saturated at the top of the range",
                 invalid_count, saturated_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/fte_pkg.sv
design/fte_decode.sv
design/fte_scale.sv
design/fte_sum.sv
design/fat_timestamp_to_epoch_core.sv
design/fte_checker.sv
dv/fte_epoch_checker.sv
dv/tb_fat_timestamp_to_epoch_core.sv
